/* rtl/core/avse_pkg.sv */
// Shared types and constants for the AV1 show-existing-frame packet scan.
package avse_pkg;

   localparam int LEB_MAX_BYTES = 8;
   localparam int SIZE_W        = 7 * LEB_MAX_BYTES;
   localparam int CNT_W         = 4;
   localparam int SHAMT_W       = 6;

   localparam logic [3:0] KIND_FRAME_HEADER = 4'd3;
   localparam logic [3:0] KIND_TILE_GROUP   = 4'd4;
   localparam logic [3:0] KIND_FRAME        = 4'd6;

   typedef enum logic [2:0] {
      PH_HDR       = 3'd0,
      PH_EXT_SIZED = 3'd1,
      PH_EXT_OPEN  = 3'd2,
      PH_LEB       = 3'd3,
      PH_PAY       = 3'd4,
      PH_TOEND     = 3'd5,
      PH_DROP      = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      OUT_SHOW  = 2'd0,
      OUT_CODED = 2'd1,
      OUT_MALF  = 2'd2,
      OUT_NONE  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  map_index;
      outcome_type outcome;
   } rsp_type;

endpackage

/* rtl/core/av1_obu_show_existing_scan.sv */
// Byte-serial AV1 OBU walker that reports whether a packet re-shows an existing frame.
//
// Usage:
//   req_ channel: one packet byte per item (req_byte_value), req_last_byte on the final byte.
//   rsp_ channel: exactly one result per packet (rsp_found, rsp_map_index, rsp_outcome),
//   issued for the byte that decides the packet; later bytes of that packet are dropped.
//   Outcome: 0 show existing, 1 coded picture, 2 malformed or truncated, 3 nothing found.
// Timing:
//   One byte per cycle while req_ready is high. The parser state is registered from the accepted byte;
//   a result is registered into out_ff, or into skid_ff while out_ff holds an untaken result.
//   The critical path is the 56-bit payload down-counter and the leb128 accumulate shift.
// Stall:
//   A two-entry result buffer sits at the output, so bytes keep flowing while one result
//   waits. req_ready drops only when both entries hold results the receiver has not taken.
// Reset:
//   Synchronous, active high. The parser returns to expecting an OBU header byte and the
//   result buffer empties.
module av1_obu_show_existing_scan (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [2:0] rsp_map_index,
   output logic [1:0] rsp_outcome
);
   import avse_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [3:0]         kind_ff, kind_in;
   logic [SIZE_W-1:0]  accum_ff, accum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]  left_ff, left_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_shown_ff, pend_shown_in;
   logic [2:0]         pend_index_ff, pend_index_in;

   rsp_type            out_ff, skid_ff, res;
   logic               out_valid_ff, skid_valid_ff;

   logic               accept, pop, fin;
   outcome_type        fin_outcome;
   logic [2:0]         fin_index;
   logic               do_hdr_tail, hdr_sized, do_size_tail;
   logic [SHAMT_W-1:0] shamt;
   logic [SIZE_W-1:0]  accum_new, left_dec;
   logic               coded;

   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign req_ready = !skid_valid_ff;

   assign shamt     = SHAMT_W'(count_ff[2:0]) * SHAMT_W'(7);
   assign accum_new = accum_ff | (SIZE_W'(req_byte_value[6:0]) << shamt);
   assign left_dec  = left_ff - SIZE_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      accum_in      = accum_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      pend_valid_in = pend_valid_ff;
      pend_shown_in = pend_shown_ff;
      pend_index_in = pend_index_ff;
      fin           = 1'b0;
      fin_outcome   = OUT_NONE;
      fin_index     = 3'd0;
      do_hdr_tail   = 1'b0;
      hdr_sized     = 1'b0;
      do_size_tail  = 1'b0;
      coded         = 1'b0;

      case (phase_ff)
         PH_DROP: begin
            if (req_last_byte) begin
               kind_in       = '0;
               accum_in      = '0;
               count_in      = '0;
               left_in       = '0;
               pend_valid_in = 1'b0;
               pend_shown_in = 1'b0;
               pend_index_in = '0;
               phase_in      = PH_HDR;
            end
         end
         PH_EXT_SIZED: begin
            do_hdr_tail = 1'b1;
            hdr_sized   = 1'b1;
         end
         PH_EXT_OPEN: begin
            do_hdr_tail = 1'b1;
         end
         PH_LEB: begin
            accum_in = accum_new;
            count_in = count_ff + CNT_W'(1);
            if (req_byte_value[7]) begin
               if (count_in >= CNT_W'(LEB_MAX_BYTES) || req_last_byte) begin
                  fin         = 1'b1;
                  fin_outcome = OUT_MALF;
               end
            end else begin
               left_in      = accum_new;
               do_size_tail = 1'b1;
            end
         end
         PH_PAY: begin
            if (kind_ff == KIND_FRAME_HEADER && !pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_shown_in = req_byte_value[7];
               pend_index_in = req_byte_value[6:4];
            end
            left_in = left_dec;
            coded   = kind_ff == KIND_FRAME || kind_ff == KIND_TILE_GROUP;
            if (left_dec == '0) begin
               if (coded) begin
                  fin         = 1'b1;
                  fin_outcome = OUT_CODED;
               end else if (pend_valid_in) begin
                  fin         = 1'b1;
                  fin_outcome = pend_shown_in ? OUT_SHOW : OUT_CODED;
                  fin_index   = pend_index_in;
               end else if (req_last_byte) begin
                  fin         = 1'b1;
                  fin_outcome = OUT_NONE;
               end else begin
                  kind_in       = '0;
                  accum_in      = '0;
                  count_in      = '0;
                  left_in       = '0;
                  pend_valid_in = 1'b0;
                  pend_shown_in = 1'b0;
                  pend_index_in = '0;
                  phase_in      = PH_HDR;
               end
            end else if (req_last_byte) begin
               fin         = 1'b1;
               fin_outcome = OUT_MALF;
            end
         end
         PH_TOEND: begin
            if (kind_ff == KIND_FRAME_HEADER) begin
               fin         = 1'b1;
               fin_outcome = req_byte_value[7] ? OUT_SHOW : OUT_CODED;
               fin_index   = req_byte_value[6:4];
            end else if (req_last_byte) begin
               fin         = 1'b1;
               fin_outcome = OUT_NONE;
            end
         end
         default: begin
            if (req_byte_value[7]) begin
               fin         = 1'b1;
               fin_outcome = OUT_MALF;
            end else begin
               kind_in       = req_byte_value[6:3];
               accum_in      = '0;
               count_in      = '0;
               left_in       = '0;
               pend_valid_in = 1'b0;
               pend_shown_in = 1'b0;
               pend_index_in = '0;
               if (req_byte_value[2]) begin
                  if (req_last_byte) begin
                     fin         = 1'b1;
                     fin_outcome = OUT_MALF;
                  end else begin
                     phase_in = req_byte_value[1] ? PH_EXT_SIZED : PH_EXT_OPEN;
                  end
               end else begin
                  do_hdr_tail = 1'b1;
                  hdr_sized   = req_byte_value[1];
               end
            end
         end
      endcase

      // end of header (and extension byte): size field or open payload
      if (do_hdr_tail) begin
         if (hdr_sized) begin
            if (req_last_byte) begin
               fin         = 1'b1;
               fin_outcome = OUT_MALF;
            end else begin
               accum_in = '0;
               count_in = '0;
               phase_in = PH_LEB;
            end
         end else if (kind_in == KIND_FRAME || kind_in == KIND_TILE_GROUP) begin
            fin         = 1'b1;
            fin_outcome = OUT_CODED;
         end else if (req_last_byte) begin
            fin         = 1'b1;
            fin_outcome = OUT_NONE;
         end else begin
            phase_in = PH_TOEND;
         end
      end

      // size field complete
      if (do_size_tail) begin
         if (accum_new == '0) begin
            if (kind_ff == KIND_FRAME || kind_ff == KIND_TILE_GROUP) begin
               fin         = 1'b1;
               fin_outcome = OUT_CODED;
            end else if (req_last_byte) begin
               fin         = 1'b1;
               fin_outcome = OUT_NONE;
            end else begin
               kind_in       = '0;
               accum_in      = '0;
               count_in      = '0;
               left_in       = '0;
               pend_valid_in = 1'b0;
               pend_shown_in = 1'b0;
               pend_index_in = '0;
               phase_in      = PH_HDR;
            end
         end else if (req_last_byte) begin
            fin         = 1'b1;
            fin_outcome = OUT_MALF;
         end else begin
            pend_valid_in = 1'b0;
            phase_in      = PH_PAY;
         end
      end

      // decision made: clear work, drop the rest of the packet
      if (fin) begin
         kind_in       = '0;
         accum_in      = '0;
         count_in      = '0;
         left_in       = '0;
         pend_valid_in = 1'b0;
         pend_shown_in = 1'b0;
         pend_index_in = '0;
         phase_in      = req_last_byte ? PH_HDR : PH_DROP;
      end
   end

   always_comb begin
      res.found     = fin_outcome == OUT_SHOW;
      res.map_index = (fin_outcome == OUT_SHOW) ? fin_index : 3'd0;
      res.outcome   = fin_outcome;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR;
         kind_ff       <= '0;
         accum_ff      <= '0;
         count_ff      <= '0;
         left_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_shown_ff <= 1'b0;
         pend_index_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         accum_ff      <= accum_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         pend_valid_ff <= pend_valid_in;
         pend_shown_ff <= pend_shown_in;
         pend_index_ff <= pend_index_in;
      end
   end

   // two-entry result buffer: out_ff is the head, skid_ff holds a second result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept && fin;
         end
      end else if (accept && fin) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept && fin) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_found     = out_ff.found;
   assign rsp_map_index = out_ff.map_index;
   assign rsp_outcome   = out_ff.outcome;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the AV1 show-existing-frame packet scan: directed and random packets.
module tb;
   import avse_pkg::*;

   localparam logic [7:0] FORBIDDEN    = 8'h80;
   localparam logic [7:0] LEB_MORE     = 8'h80;
   localparam logic [3:0] KIND_SEQ_HDR = 4'd1;
   localparam logic [3:0] KIND_TD      = 4'd2;
   localparam int         NUM_BYTES    = 1550;

   // Tracks the parse of the byte stream and holds the decisions still owed by the block.
   class reshow_scoreboard;
      phase_type         phase;
      logic [3:0]        kind;
      logic [SIZE_W-1:0] accum;
      logic [SIZE_W-1:0] left;
      logic [3:0]        nbytes;
      bit                pend_valid;
      bit                pend_shown;
      logic [2:0]        pend_index;
      rsp_type           decision_q[$];
      int                errors;

      function new();
         clear_obu();
         phase  = PH_HDR;
         errors = 0;
      endfunction

      function void clear_obu();
         kind       = '0;
         accum      = '0;
         left       = '0;
         nbytes     = '0;
         pend_valid = 1'b0;
         pend_shown = 1'b0;
         pend_index = '0;
      endfunction

      function void decide(outcome_type oc, logic [2:0] idx, bit last);
         rsp_type r;
         r.found     = (oc == OUT_SHOW);
         r.map_index = (oc == OUT_SHOW) ? idx : 3'd0;
         r.outcome   = oc;
         decision_q.push_back(r);
         clear_obu();
         phase = last ? PH_HDR : PH_DROP;
      endfunction

      function bit coded();
         return kind == KIND_FRAME || kind == KIND_TILE_GROUP;
      endfunction

      function void obu_done(bit last);
         if (last) begin
            decide(OUT_NONE, 3'd0, 1'b1);
         end else begin
            clear_obu();
            phase = PH_HDR;
         end
      endfunction

      function void header_done(bit sized, bit last);
         if (sized) begin
            if (last) begin
               decide(OUT_MALF, 3'd0, 1'b1);
            end else begin
               accum  = '0;
               nbytes = '0;
               phase  = PH_LEB;
            end
         end else if (coded()) begin
            decide(OUT_CODED, 3'd0, last);
         end else if (last) begin
            decide(OUT_NONE, 3'd0, 1'b1);
         end else begin
            phase = PH_TOEND;
         end
      endfunction

      function void size_done(bit last);
         if (left == 0) begin
            if (coded()) decide(OUT_CODED, 3'd0, last);
            else obu_done(last);
         end else if (last) begin
            decide(OUT_MALF, 3'd0, 1'b1);
         end else begin
            pend_valid = 1'b0;
            phase      = PH_PAY;
         end
      endfunction

      // Returns 0 for a byte dropped after the packet was decided.
      function bit parse_byte(logic [7:0] b, bit last);
         case (phase)
            PH_DROP: begin
               if (last) begin
                  clear_obu();
                  phase = PH_HDR;
               end
               return 1'b0;
            end
            PH_EXT_SIZED: header_done(1'b1, last);
            PH_EXT_OPEN:  header_done(1'b0, last);
            PH_LEB: begin
               accum = accum | (SIZE_W'(b[6:0]) << (7 * nbytes[2:0]));
               nbytes = nbytes + 4'd1;
               if (b[7]) begin
                  if (nbytes >= LEB_MAX_BYTES || last) decide(OUT_MALF, 3'd0, last);
               end else begin
                  left = accum;
                  size_done(last);
               end
            end
            PH_PAY: begin
               if (kind == KIND_FRAME_HEADER && !pend_valid) begin
                  pend_valid = 1'b1;
                  pend_shown = b[7];
                  pend_index = b[6:4];
               end
               left = left - 1'b1;
               if (left == 0) begin
                  // sized decision only counts once the whole payload is inside the packet
                  if (coded()) decide(OUT_CODED, 3'd0, last);
                  else if (pend_valid) decide(pend_shown ? OUT_SHOW : OUT_CODED, pend_index, last);
                  else obu_done(last);
               end else if (last) begin
                  decide(OUT_MALF, 3'd0, 1'b1);
               end
            end
            PH_TOEND: begin
               if (kind == KIND_FRAME_HEADER) decide(b[7] ? OUT_SHOW : OUT_CODED, b[6:4], last);
               else if (last) decide(OUT_NONE, 3'd0, 1'b1);
            end
            default: begin
               if (b[7]) begin
                  decide(OUT_MALF, 3'd0, last);
               end else begin
                  clear_obu();
                  kind = b[6:3];
                  if (b[2]) begin
                     if (last) decide(OUT_MALF, 3'd0, 1'b1);
                     else phase = b[1] ? PH_EXT_SIZED : PH_EXT_OPEN;
                  end else begin
                     header_done(b[1], last);
                  end
               end
            end
         endcase
         return 1'b1;
      endfunction

      task flag_mismatch(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic f, logic [2:0] idx, logic [1:0] oc);
         rsp_type e;
         if (decision_q.size() == 0) begin
            flag_mismatch($sformatf("result with none pending: found=%0b index=%0d outcome=%0d",
                                    f, idx, oc));
            return;
         end
         e = decision_q.pop_front();
         if (f !== e.found)
            flag_mismatch($sformatf("found %0b, expected %0b", f, e.found));
         if (idx !== e.map_index)
            flag_mismatch($sformatf("map_index %0d, expected %0d", idx, e.map_index));
         if (oc !== e.outcome)
            flag_mismatch($sformatf("outcome %0d, expected %0d", oc, e.outcome));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_byte_value;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_found;
   logic [2:0] rsp_map_index;
   logic [1:0] rsp_outcome;

   reshow_scoreboard sb = new();
   logic [7:0]       pkt_q[$];
   bit               calm = 1'b0;
   int               hold_left = 0;
   int               parsed = 0;

   av1_obu_show_existing_scan uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_map_index  (rsp_map_index),
      .rsp_outcome    (rsp_outcome)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] obu_hdr(logic [3:0] k, bit ext, bit sized, bit rsv);
      return {1'b0, k, ext, sized, rsv};
   endfunction

   function void push_leb(int unsigned v, int pad);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0 || pad > 0) b = b | LEB_MORE;
         pkt_q.push_back(b);
      end while (v != 0);
      while (pad > 0) begin
         pad--;
         pkt_q.push_back(pad > 0 ? LEB_MORE : 8'h00);
      end
   endfunction

   // One OBU with random content; open is set when it has no size field.
   function void add_obu(output bit open);
      int unsigned r;
      int unsigned n;
      int          pad;
      logic [3:0]  k;
      bit          ext;
      bit          sized;
      r = $urandom_range(99);
      if (r < 30) k = KIND_FRAME_HEADER;
      else if (r < 42) k = KIND_FRAME;
      else if (r < 52) k = KIND_TILE_GROUP;
      else k = 4'($urandom_range(15));
      ext   = ($urandom_range(3) == 0);
      sized = ($urandom_range(7) != 0);
      pkt_q.push_back(obu_hdr(k, ext, sized, 1'($urandom_range(1))));
      if (ext) pkt_q.push_back(8'($urandom));
      if (sized) begin
         n = ($urandom_range(19) == 0) ? $urandom_range(6, 200) : $urandom_range(0, 5);
         // non-minimal size fields, up to the full eight bytes
         pad = ($urandom_range(4) == 0) ? $urandom_range(1, (n < 128) ? 7 : 6) : 0;
         push_leb(n, pad);
      end else begin
         n = $urandom_range(0, 4);
      end
      for (int i = 0; i < n; i++) pkt_q.push_back(8'($urandom));
      open = !sized;
   endfunction

   function void build_packet();
      int unsigned nobu;
      bit          open;
      pkt_q.delete();
      nobu = $urandom_range(1, 3);
      for (int i = 0; i < nobu; i++) begin
         add_obu(open);
         if (open) break;
      end
   endfunction

   function bit idle_roll();
      return !calm && ($urandom_range(99) < 30);
   endfunction

   task send_byte(logic [7:0] b, bit last);
      while (idle_roll()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_last_byte  <= last;
      do @(posedge clock); while (!req_ready);
      void'(sb.parse_byte(b, last));
      parsed++;
   endtask

   task send_pkt(int last_at);
      for (int i = 0; i <= last_at; i++) send_byte(pkt_q[i], i == last_at);
      pkt_q.delete();
   endtask

   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.decision_q.size() != 0);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_found, rsp_map_index, rsp_outcome);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 30);
         end
      end
   end

   initial begin
      int unsigned r;
      int          pk;
      int          n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_value = 8'h00;
      req_last_byte  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // forbidden bit
      pkt_q = '{FORBIDDEN | obu_hdr(KIND_FRAME, 1'b0, 1'b1, 1'b0)};
      send_pkt(0);
      // re-shown frame, map index 7
      pkt_q = '{obu_hdr(KIND_FRAME_HEADER, 1'b0, 1'b1, 1'b0), 8'h01, 8'hF0};
      send_pkt(2);
      // empty temporal delimiter, empty frame OBU, then a dropped trailing byte
      pkt_q = '{obu_hdr(KIND_TD, 1'b0, 1'b1, 1'b0), 8'h00,
                obu_hdr(KIND_FRAME, 1'b0, 1'b1, 1'b0), 8'h00, 8'hFF};
      send_pkt(4);
      // packet ends where the extension byte should be
      pkt_q = '{obu_hdr(KIND_FRAME_HEADER, 1'b1, 1'b1, 1'b0)};
      send_pkt(0);
      // size field still continuing after eight bytes
      pkt_q = '{obu_hdr(KIND_SEQ_HDR, 1'b0, 1'b1, 1'b0)};
      repeat (LEB_MAX_BYTES) pkt_q.push_back(LEB_MORE);
      send_pkt(LEB_MAX_BYTES);
      // frame header without size field, coded picture
      pkt_q = '{obu_hdr(KIND_FRAME_HEADER, 1'b0, 1'b0, 1'b0), 8'h0F};
      send_pkt(1);
      // empty frame header, then an unsized OBU running to the end
      pkt_q = '{obu_hdr(KIND_FRAME_HEADER, 1'b0, 1'b1, 1'b0), 8'h00,
                obu_hdr(KIND_TD, 1'b0, 1'b0, 1'b0), 8'h55};
      send_pkt(3);
      // declared payload larger than the packet
      pkt_q = '{obu_hdr(KIND_TILE_GROUP, 1'b0, 1'b1, 1'b0), 8'h05, 8'h00};
      send_pkt(2);

      pk = 0;
      while (parsed < NUM_BYTES) begin
         calm = (pk >= 50 && pk < 75);
         if (pk == 5) hold_left = 250;
         if (pk == 35) drain();
         r = $urandom_range(99);
         if (r < 80) begin
            build_packet();
            send_pkt(pkt_q.size() - 1);
         end else if (r < 90) begin
            // packet cut short at a random byte
            build_packet();
            send_pkt($urandom_range(pkt_q.size() - 1));
         end else if (r < 95) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               send_byte(8'($urandom), (i == n - 1) || ($urandom_range(3) == 0));
         end else begin
            // long or overlong size field with random groups
            pkt_q.delete();
            pkt_q.push_back(obu_hdr(4'($urandom_range(15)), 1'b0, 1'b1, 1'b0));
            n = $urandom_range(1, LEB_MAX_BYTES + 1);
            for (int j = 0; j < n; j++) pkt_q.push_back({j < n - 1, 7'($urandom)});
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
            send_pkt(pkt_q.size() - 1);
         end
         pk++;
      end
      calm = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end
endmodule
